>>> rtl/abu_pkg.sv
// abu_pkg: shared types and constants for the A/B update slot controller.
// Holds the command classes, slot state codes and the queued work item.
// No dependencies.
`default_nettype none

package abu_pkg;

	// Largest block one write may carry, in bytes.
	localparam logic [31:0] MAX_BLOCK = 32'd4096;

	// Raw command codes on the input channel.
	localparam logic [3:0] CMD_RESET    = 4'd0;
	localparam logic [3:0] CMD_BEGIN    = 4'd1;
	localparam logic [3:0] CMD_WRITE    = 4'd2;
	localparam logic [3:0] CMD_ABORT    = 4'd3;
	localparam logic [3:0] CMD_END      = 4'd4;
	localparam logic [3:0] CMD_SELECT   = 4'd5;
	localparam logic [3:0] CMD_REBOOT   = 4'd6;
	localparam logic [3:0] CMD_CONFIRM  = 4'd7;
	localparam logic [3:0] CMD_ROLLBACK = 4'd8;
	localparam logic [3:0] CMD_QUERY    = 4'd9;

	// Status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// Decoded operation class; unused command codes land in OP_BAD.
	typedef enum logic [3:0] {
		OP_RESET,
		OP_BEGIN,
		OP_WRITE,
		OP_ABORT,
		OP_END,
		OP_SELECT,
		OP_REBOOT,
		OP_CONFIRM,
		OP_ROLLBACK,
		OP_QUERY,
		OP_BAD
	} op_t;

	// Per-slot state codes.
	typedef enum logic [2:0] {
		ST_EMPTY   = 3'd0,
		ST_VALID   = 3'd1,
		ST_STAGING = 3'd2,
		ST_PENDING = 3'd3,
		ST_INVALID = 3'd4,
		ST_ABORTED = 3'd5
	} slot_state_t;

	// Classified command as it travels from front to back.
	typedef struct packed {
		op_t         op;
		logic [1:0]  slot;
		logic [31:0] length;
		logic        verify_pass;
		logic        len_zero;
		logic        len_over;
	} work_t;

endpackage

`default_nettype wire

>>> rtl/ab_update_slot_controller.sv
// ab_update_slot_controller: two-slot A/B firmware update controller.
// Top level; instantiates abu_front, abu_queue and abu_back; uses abu_pkg.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   command, slot, length, verify_pass
//   out      from block out_valid / out_ready status, boot_slot_now,
//                                             running_slot_now, target_slot_now,
//                                             queried_state
//
// Every command yields one result. In the back end, one 33-bit add and compare
// on the byte counters sets the path. Sustained rate is one command per cycle
// while the output is not stalled; a command is written into the queue when it
// transfers, then executed from the queue head into the output register.
// Reset restores slot 0 valid and running, slot 1 empty and targeted.
// A stalled output fills the queue; in_ready drops only when it is full.
`default_nettype none

module ab_update_slot_controller
	import abu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  command,
	input  wire logic [1:0]  slot,
	input  wire logic [31:0] length,
	input  wire logic        verify_pass,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic             boot_slot_now,
	output logic             running_slot_now,
	output logic             target_slot_now,
	output logic [2:0]       queried_state
);

	work_t front_item;
	work_t head_item;
	logic  q_full, q_empty, q_push, q_pop;

	// Front: classify the command and its length.
	abu_front u_front (
		.command     (command),
		.slot        (slot),
		.length      (length),
		.verify_pass (verify_pass),
		.item        (front_item)
	);

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Queue decouples command intake from execution.
	abu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: apply the command to slot state and register the result.
	abu_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (head_item),
		.item_valid       (!q_empty),
		.item_take        (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.boot_slot_now    (boot_slot_now),
		.running_slot_now (running_slot_now),
		.target_slot_now  (target_slot_now),
		.queried_state    (queried_state)
	);

endmodule

`default_nettype wire

>>> rtl/abu_front.sv
// abu_front: decodes raw commands into work items for the queue.
// Depends on abu_pkg.
`default_nettype none

module abu_front
	import abu_pkg::*;
(
	input  wire logic [3:0]  command,
	input  wire logic [1:0]  slot,
	input  wire logic [31:0] length,
	input  wire logic        verify_pass,
	output work_t            item
);

	op_t op;

	always_comb begin
		unique case (command)
			CMD_RESET:    op = OP_RESET;
			CMD_BEGIN:    op = OP_BEGIN;
			CMD_WRITE:    op = OP_WRITE;
			CMD_ABORT:    op = OP_ABORT;
			CMD_END:      op = OP_END;
			CMD_SELECT:   op = OP_SELECT;
			CMD_REBOOT:   op = OP_REBOOT;
			CMD_CONFIRM:  op = OP_CONFIRM;
			CMD_ROLLBACK: op = OP_ROLLBACK;
			CMD_QUERY:    op = OP_QUERY;
			default:      op = OP_BAD;
		endcase
	end

	// Length checks that do not depend on controller state are done here.
	always_comb begin
		item.op          = op;
		item.slot        = slot;
		item.length      = length;
		item.verify_pass = verify_pass;
		item.len_zero    = (length == 32'd0);
		item.len_over    = (length > MAX_BLOCK);
	end

endmodule

`default_nettype wire

>>> rtl/abu_queue.sv
// abu_queue: small FIFO of work items between front and back.
// Depends on abu_pkg.
`default_nettype none

module abu_queue
	import abu_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire work_t push_item,
	input  wire logic  pop,
	output work_t      head_item,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// No push into a full queue, no pop from an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/abu_back.sv
// abu_back: executes work items against the slot controller state and
// holds the result in an output register. Depends on abu_pkg.
`default_nettype none

module abu_back
	import abu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire work_t item,
	input  wire logic  item_valid,
	output logic       item_take,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic       status,
	output logic       boot_slot_now,
	output logic       running_slot_now,
	output logic       target_slot_now,
	output logic [2:0] queried_state
);

	slot_state_t st0_q, st1_q, st0_nx, st1_nx;
	logic        run_q, boot_q, tgt_q, run_nx, boot_nx, tgt_nx;
	logic [31:0] exp_q, wr_q, exp_nx, wr_nx;
	logic        stg_q, ver_q, stg_nx, ver_nx;
	logic        ok;
	logic        set_en, set_sel;
	slot_state_t set_val;
	slot_state_t st_run, st_oth, st_tgt, st_qry;
	logic [32:0] wr_sum;
	logic        rst_slot;

	logic        out_valid_q;
	logic        status_q, boot_q_out, run_q_out, tgt_q_out;
	slot_state_t qry_q;

	assign item_take = item_valid && (!out_valid_q || out_ready);

	assign st_run   = run_q ? st1_q : st0_q;
	assign st_oth   = run_q ? st0_q : st1_q;
	assign st_tgt   = tgt_q ? st1_q : st0_q;
	assign wr_sum   = {1'b0, wr_q} + {1'b0, item.length};
	assign rst_slot = item.slot[1] ? 1'b0 : item.slot[0];

	always_comb begin
		st0_nx  = st0_q;
		st1_nx  = st1_q;
		run_nx  = run_q;
		boot_nx = boot_q;
		tgt_nx  = tgt_q;
		exp_nx  = exp_q;
		wr_nx   = wr_q;
		stg_nx  = stg_q;
		ver_nx  = ver_q;
		ok      = 1'b0;
		set_en  = 1'b0;
		set_sel = tgt_q;
		set_val = ST_EMPTY;
		unique case (item.op)
			OP_RESET: begin
				st0_nx  = rst_slot ? ST_EMPTY : ST_VALID;
				st1_nx  = rst_slot ? ST_VALID : ST_EMPTY;
				run_nx  = rst_slot;
				boot_nx = rst_slot;
				tgt_nx  = ~rst_slot;
				exp_nx  = '0;
				wr_nx   = '0;
				stg_nx  = 1'b0;
				ver_nx  = 1'b0;
				ok      = 1'b1;
			end
			OP_BEGIN: begin
				if (!item.slot[1] && item.slot[0] != run_q && !item.len_zero && !stg_q) begin
					tgt_nx  = item.slot[0];
					exp_nx  = item.length;
					wr_nx   = '0;
					ver_nx  = 1'b0;
					stg_nx  = 1'b1;
					set_en  = 1'b1;
					set_sel = item.slot[0];
					set_val = ST_STAGING;
					ok      = 1'b1;
				end
			end
			OP_WRITE: begin
				if (stg_q && !item.len_zero && !item.len_over && wr_sum <= {1'b0, exp_q}) begin
					wr_nx = wr_sum[31:0];
					ok    = 1'b1;
				end
			end
			OP_ABORT: begin
				if (stg_q) begin
					stg_nx  = 1'b0;
					ver_nx  = 1'b0;
					wr_nx   = '0;
					exp_nx  = '0;
					set_en  = 1'b1;
					set_val = ST_ABORTED;
					ok      = 1'b1;
				end
			end
			OP_END: begin
				if (stg_q) begin
					stg_nx = 1'b0;
					set_en = 1'b1;
					if (wr_q != exp_q || !item.verify_pass) begin
						ver_nx  = 1'b0;
						set_val = ST_INVALID;
					end else begin
						ver_nx  = 1'b1;
						set_val = ST_PENDING;
						ok      = 1'b1;
					end
				end
			end
			OP_SELECT: begin
				if (ver_q && st_tgt == ST_PENDING) begin
					boot_nx = tgt_q;
					ok      = 1'b1;
				end
			end
			OP_REBOOT: begin
				if (!stg_q) begin
					run_nx = boot_q;
					ver_nx = 1'b0;
					ok     = 1'b1;
				end
			end
			OP_CONFIRM: begin
				if (st_run == ST_VALID) begin
					ok = 1'b1;
				end else if (st_run == ST_PENDING) begin
					set_en  = 1'b1;
					set_sel = run_q;
					set_val = ST_VALID;
					ok      = 1'b1;
				end
			end
			OP_ROLLBACK: begin
				if (st_run == ST_PENDING && st_oth == ST_VALID) begin
					set_en  = 1'b1;
					set_sel = run_q;
					set_val = ST_INVALID;
					boot_nx = ~run_q;
					run_nx  = ~run_q;
					ver_nx  = 1'b0;
					ok      = 1'b1;
				end
			end
			OP_QUERY: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (set_en) begin
			if (set_sel) begin
				st1_nx = set_val;
			end else begin
				st0_nx = set_val;
			end
		end
	end

	assign st_qry = item.slot[1] ? ST_INVALID : (item.slot[0] ? st1_nx : st0_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st0_q  <= ST_VALID;
			st1_q  <= ST_EMPTY;
			run_q  <= 1'b0;
			boot_q <= 1'b0;
			tgt_q  <= 1'b1;
			exp_q  <= '0;
			wr_q   <= '0;
			stg_q  <= 1'b0;
			ver_q  <= 1'b0;
		end else if (item_take) begin
			st0_q  <= st0_nx;
			st1_q  <= st1_nx;
			run_q  <= run_nx;
			boot_q <= boot_nx;
			tgt_q  <= tgt_nx;
			exp_q  <= exp_nx;
			wr_q   <= wr_nx;
			stg_q  <= stg_nx;
			ver_q  <= ver_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			status_q   <= ok ? STATUS_OK : STATUS_REFUSED;
			boot_q_out <= boot_nx;
			run_q_out  <= run_nx;
			tgt_q_out  <= tgt_nx;
			qry_q      <= st_qry;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign boot_slot_now    = boot_q_out;
	assign running_slot_now = run_q_out;
	assign target_slot_now  = tgt_q_out;
	assign queried_state    = qry_q;

	// While staging, the target slot is marked staging and is not the running slot.
	a_stage_target: assert property (@(posedge clk) disable iff (!arst_n)
		stg_q |-> ((tgt_q ? st1_q : st0_q) == ST_STAGING))
		else $error("staging target not in staging state");
	a_stage_not_run: assert property (@(posedge clk) disable iff (!arst_n)
		stg_q |-> (tgt_q != run_q))
		else $error("staging the running slot");
	a_verified_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ver_q |-> !stg_q)
		else $error("verified while staging");
	a_written_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stg_q |-> (wr_q <= exp_q))
		else $error("written bytes exceed expected");

endmodule

`default_nettype wire
